// ===== rtl/core/ium_pkg.sv =====
// ium_pkg: shared types and constants for the interval union merger
// no dependencies; used by the channel interfaces, controller, datapath and top
package ium_pkg;

  // fixed widths of the channel fields
  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW   = 6;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [IdxW-1:0]          idx_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the input transaction, set ptr to fill count
    logic ins_rd;     // read entry ptr-1 during insertion
    logic ins_shift;  // move read entry up to ptr, step ptr down
    logic ins_place;  // write the new interval at ptr, bump fill count
    logic sw_init;    // start a sweep at entry 0
    logic sw_rd;      // read entry ptr during the sweep
    logic sw_step;    // fold the read entry into the running interval
    logic emit;       // load the output register with the running interval
    logic emit_last;  // mark the emitted interval as the final one
    logic set_clear;  // set is done, return counters to zero
  } ium_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;        // buffer holds the maximum number of entries
    logic ptr_zero;    // insertion reached the bottom of the buffer
    logic ptr_at_cnt;  // sweep has visited every stored entry
    logic item_last;   // latched transaction closes the set
    logic new_lt_rd;   // new interval sorts below the read entry
    logic open;        // a running interval exists
    logic gap;         // read entry starts past the running right end
    logic slot_free;   // output register can take a result
  } ium_sts_t;

endpackage

// ===== rtl/core/ium_if.sv =====
// ium_if: valid/ready channel interfaces for input intervals and merged results
// depends on ium_pkg for the field types
interface ium_in_if;
  import ium_pkg::*;

  logic   valid;
  logic   ready;
  coord_t left_end;
  coord_t right_end;
  logic   set_last;

  modport source (output valid, output left_end, output right_end, output set_last,
                  input ready);
  modport sink (input valid, input left_end, input right_end, input set_last,
                output ready);
endinterface

interface ium_out_if;
  import ium_pkg::*;

  logic   valid;
  logic   ready;
  coord_t merged_left;
  coord_t merged_right;
  idx_t   merged_index;
  logic   run_last;
  logic   dropped_any;

  modport source (output valid, output merged_left, output merged_right,
                  output merged_index, output run_last, output dropped_any,
                  input ready);
  modport sink (input valid, input merged_left, input merged_right,
                input merged_index, input run_last, input dropped_any,
                output ready);
endinterface

// ===== rtl/core/ium_dp.sv =====
// ium_dp: interval buffer memory, insertion and sweep registers, output register
// depends on ium_pkg; driven by ium_ctrl through ium_cmd_t / ium_sts_t
module ium_dp #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned COORD_BITS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ium_pkg::coord_t    left_end_i,
  input  ium_pkg::coord_t    right_end_i,
  input  logic               set_last_i,
  input  ium_pkg::ium_cmd_t  cmd_i,
  output ium_pkg::ium_sts_t  sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output ium_pkg::coord_t    merged_left_o,
  output ium_pkg::coord_t    merged_right_o,
  output ium_pkg::idx_t      merged_index_o,
  output logic               run_last_o,
  output logic               dropped_any_o
);
  import ium_pkg::*;

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned EW = 2 * COORD_BITS;

  // interval buffer, kept sorted by (left, right) as items arrive
  logic [EW-1:0] mem_q [MAX_INTERVALS];
  logic [EW-1:0] rd_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] ptr_m1;
  logic          ovf_q, ovf_d;
  logic          open_q, open_d;
  idx_t          idx_q, idx_d;
  logic          out_valid_q, out_valid_d;

  logic [COORD_BITS-1:0] new_l_q, new_r_q;
  logic                  last_q;
  logic [COORD_BITS-1:0] start_q, end_q;
  logic [COORD_BITS-1:0] in_l, in_r;
  logic [COORD_BITS-1:0] rd_l, rd_r;
  coord_t                start_ext, end_ext;

  coord_t out_left_q, out_right_q;
  idx_t   out_idx_q;
  logic   out_last_q, out_drop_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic          slot_free;

  // coordinate width adaptation at the channel boundary
  if (COORD_BITS <= CoordW) begin : g_in_narrow
    assign in_l = left_end_i[COORD_BITS-1:0];
    assign in_r = right_end_i[COORD_BITS-1:0];
  end else begin : g_in_wide
    assign in_l = {{(COORD_BITS-CoordW){left_end_i[CoordW-1]}}, left_end_i};
    assign in_r = {{(COORD_BITS-CoordW){right_end_i[CoordW-1]}}, right_end_i};
  end

  if (COORD_BITS >= CoordW) begin : g_out_wide
    assign start_ext = start_q[CoordW-1:0];
    assign end_ext   = end_q[CoordW-1:0];
  end else begin : g_out_narrow
    assign start_ext = {{(CoordW-COORD_BITS){start_q[COORD_BITS-1]}}, start_q};
    assign end_ext   = {{(CoordW-COORD_BITS){end_q[COORD_BITS-1]}}, end_q};
  end

  assign rd_l   = rd_q[EW-1:COORD_BITS];
  assign rd_r   = rd_q[COORD_BITS-1:0];
  assign ptr_m1 = ptr_q - CW'(1);

  // memory port control
  assign re    = cmd_i.ins_rd | cmd_i.sw_rd;
  assign raddr = cmd_i.sw_rd ? ptr_q[AW-1:0] : ptr_m1[AW-1:0];
  assign we    = cmd_i.ins_shift | cmd_i.ins_place;
  assign waddr = ptr_q[AW-1:0];
  assign wdata = cmd_i.ins_shift ? rd_q : {new_l_q, new_r_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  // status toward the controller
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.full       = (cnt_q == CW'(MAX_INTERVALS));
    sts_o.ptr_zero   = (ptr_q == '0);
    sts_o.ptr_at_cnt = (ptr_q == cnt_q);
    sts_o.item_last  = last_q;
    sts_o.new_lt_rd  = ($signed(new_l_q) < $signed(rd_l)) ||
                       ((new_l_q == rd_l) && ($signed(new_r_q) < $signed(rd_r)));
    sts_o.open       = open_q;
    sts_o.gap        = ($signed(end_q) < $signed(rd_l));
    sts_o.slot_free  = slot_free;
  end

  // control state next values
  always_comb begin
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    ovf_d       = ovf_q;
    open_d      = open_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.capture) begin
      ptr_d = cnt_q;
      if (cnt_q == CW'(MAX_INTERVALS)) begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.ins_shift) begin
      ptr_d = ptr_m1;
    end
    if (cmd_i.ins_place) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.sw_step) begin
      ptr_d  = ptr_q + CW'(1);
      open_d = 1'b1;
    end
    if (cmd_i.sw_init) begin
      ptr_d  = '0;
      open_d = 1'b0;
      idx_d  = '0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + IdxW'(1);
    end
    if (cmd_i.set_clear) begin
      cnt_d  = '0;
      ovf_d  = 1'b0;
      open_d = 1'b0;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      ovf_q       <= 1'b0;
      open_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      ovf_q       <= ovf_d;
      open_q      <= open_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: latched item, running interval, output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      new_l_q <= in_l;
      new_r_q <= in_r;
      last_q  <= set_last_i;
    end
    if (cmd_i.sw_step) begin
      if (!open_q || ($signed(end_q) < $signed(rd_l))) begin
        start_q <= rd_l;
        end_q   <= rd_r;
      end else if ($signed(end_q) < $signed(rd_r)) begin
        end_q <= rd_r;
      end
    end
    if (cmd_i.emit) begin
      out_left_q  <= start_ext;
      out_right_q <= end_ext;
      out_idx_q   <= idx_q;
      out_last_q  <= cmd_i.emit_last;
      out_drop_q  <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign merged_left_o  = out_left_q;
  assign merged_right_o = out_right_q;
  assign merged_index_o = out_idx_q;
  assign run_last_o     = out_last_q;
  assign dropped_any_o  = out_drop_q;

`ifndef ASSERT_OFF
  // fill count never passes the buffer size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_INTERVALS))
    else $error("fill count beyond buffer size");

  // a result is never loaded over one that is still waiting
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> slot_free)
    else $error("result overwritten while stalled");

  // no write into a full buffer
  a_place_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_place |-> (cnt_q != CW'(MAX_INTERVALS)))
    else $error("insertion into full buffer");

  // a finished set leaves an empty buffer and no running interval
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_clear |=> (cnt_q == '0) && !open_q && !ovf_q)
    else $error("set state not cleared");
`endif

endmodule

// ===== rtl/core/ium_ctrl.sv =====
// ium_ctrl: state machine sequencing load, sorted insertion, sweep and emission
// depends on ium_pkg; commands ium_dp through ium_cmd_t, reads ium_sts_t
module ium_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  ium_pkg::ium_sts_t  sts_i,
  output ium_pkg::ium_cmd_t  cmd_o
);
  import ium_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_RD  = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_SW_RD   = 3'd3;
  localparam logic [2:0] ST_SW_CMP  = 3'd4;
  localparam logic [2:0] ST_SW_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!sts_i.full) begin
            state_d = ST_INS_RD;
          end else if (in_last_i) begin
            cmd_o.sw_init = 1'b1;
            state_d       = ST_SW_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (sts_i.ptr_zero) begin
          cmd_o.ins_place = 1'b1;
          cmd_o.sw_init   = sts_i.item_last;
          state_d         = sts_i.item_last ? ST_SW_RD : ST_IDLE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.new_lt_rd) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = ST_INS_RD;
        end else begin
          cmd_o.ins_place = 1'b1;
          cmd_o.sw_init   = sts_i.item_last;
          state_d         = sts_i.item_last ? ST_SW_RD : ST_IDLE;
        end
      end
      ST_SW_RD: begin
        if (sts_i.ptr_at_cnt) begin
          state_d = ST_SW_FIN;
        end else begin
          cmd_o.sw_rd = 1'b1;
          state_d     = ST_SW_CMP;
        end
      end
      ST_SW_CMP: begin
        // a gap closes the running interval, which needs the output register
        if (!(sts_i.open && sts_i.gap && !sts_i.slot_free)) begin
          cmd_o.sw_step = 1'b1;
          cmd_o.emit    = sts_i.open && sts_i.gap;
          state_d       = ST_SW_RD;
        end
      end
      ST_SW_FIN: begin
        if (sts_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.set_clear = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  // the final result only leaves from the closing state
  a_last_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_last |-> (state_q == ST_SW_FIN))
    else $error("final result outside closing state");

  // a sweep always begins from the first entry with nothing open
  a_sweep_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SW_RD && state_d == ST_SW_RD && state_q != ST_SW_CMP) |-> cmd_o.sw_init)
    else $error("sweep entered without init");

  // the final state is never reached with no interval open
  a_fin_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SW_FIN) |-> sts_i.open)
    else $error("closing a set with no interval");
`endif

endmodule

// ===== rtl/core/interval_union_merger_top.sv =====
// interval_union_merger_top: merges overlapping closed intervals of one set
// depends on ium_pkg, ium_if, ium_ctrl and ium_dp
//
// Usage: intervals arrive one per transaction on in_i (left_end, right_end,
// set_last). Each is inserted into a buffer of MAX_INTERVALS entries kept
// sorted by left end, then right end. An interval arriving with the buffer full
// is dropped and the set's results carry dropped_any. The transaction with
// set_last closes the set: a sweep walks the buffer, merges intervals that
// overlap or touch, and sends each merged interval on out_o in ascending order
// with its index (modulo 64) and run_last on the final one.
// Steps: an item is latched, then each stored entry that sorts above it is
// read, compared and shifted up one place, one read and compare per step; the
// item is written once an entry sorts at or below it or the bottom is reached.
// An item dropped on a full buffer is only latched. The sweep reads and folds
// each stored entry in turn, then sends the final result from a closing state.
// in_i.ready is high only while no item is in work; out_o has a result
// register, and a stalled receiver holds the sweep at the next result.
// Reset clears the counters, the running interval and the output valid;
// the buffer itself is not cleared and needs no clearing pass.
module interval_union_merger_top #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned COORD_BITS    = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ium_in_if.sink           in_i,
  ium_out_if.source        out_o
);
  import ium_pkg::*;

  ium_cmd_t cmd;
  ium_sts_t sts;

  // sequencer
  ium_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.set_last),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // buffer and merge datapath
  ium_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .left_end_i     (in_i.left_end),
    .right_end_i    (in_i.right_end),
    .set_last_i     (in_i.set_last),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .merged_left_o  (out_o.merged_left),
    .merged_right_o (out_o.merged_right),
    .merged_index_o (out_o.merged_index),
    .run_last_o     (out_o.run_last),
    .dropped_any_o  (out_o.dropped_any)
  );

endmodule

// ===== verif/interval_union_merger_top_tb.sv =====
`timescale 1ns / 100ps
// interval_union_merger_top_tb: self-checking bench for interval_union_merger_top
// sends interval sets on ium_in_if and checks merged runs on ium_out_if against a
// local sort-and-sweep model; depends on ium_pkg, ium_if and the rtl top
module interval_union_merger_top_tb;
  import ium_pkg::*;

  localparam int unsigned SetCap     = 64;
  localparam int unsigned DirN       = 21;
  localparam int unsigned RandItems  = 385;
  localparam int unsigned QuietTail  = 40;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned StuckLimit = 4000;
  localparam coord_t      CoordMin   = 32'sh8000_0000;
  localparam coord_t      CoordMax   = 32'sh7fff_ffff;

  typedef struct packed {
    coord_t left;
    coord_t right;
  } span_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    idx_t   index;
    logic   is_last;
    logic   dropped;
  } merged_t;

  typedef struct packed {
    coord_t  left;
    coord_t  right;
    logic    set_last;
    logic    typed;
    merged_t want;
  } dir_row_t;

  localparam merged_t NoWant = '0;

  // directed sets; typed rows carry a result that is obvious by hand
  localparam dir_row_t DirRows [DirN] = '{
    // lone interval right after reset
    '{32'sd5, 32'sd9, 1'b1, 1'b1, '{32'sd5, 32'sd9, 6'd0, 1'b1, 1'b0}},
    // coordinate extremes
    '{CoordMin, CoordMax, 1'b1, 1'b1, '{CoordMin, CoordMax, 6'd0, 1'b1, 1'b0}},
    '{CoordMin, CoordMin, 1'b1, 1'b1, '{CoordMin, CoordMin, 6'd0, 1'b1, 1'b0}},
    '{CoordMax, CoordMax, 1'b1, 1'b1, '{CoordMax, CoordMax, 6'd0, 1'b1, 1'b0}},
    // reversed interval alone is passed through as given
    '{32'sd10, 32'sd5, 1'b1, 1'b1, '{32'sd10, 32'sd5, 6'd0, 1'b1, 1'b0}},
    // touching endpoints merge
    '{32'sd1, 32'sd3, 1'b0, 1'b0, NoWant},
    '{32'sd3, 32'sd5, 1'b1, 1'b1, '{32'sd1, 32'sd5, 6'd0, 1'b1, 1'b0}},
    // unsorted disjoint intervals and points, several results
    '{32'sd20, 32'sd25, 1'b0, 1'b0, NoWant},
    '{32'sd1, 32'sd2, 1'b0, 1'b0, NoWant},
    '{32'sd4, 32'sd4, 1'b0, 1'b0, NoWant},
    '{32'sd3, 32'sd3, 1'b1, 1'b0, NoWant},
    // equal left ends and a reversed interval inside a run
    '{32'sd7, 32'sd12, 1'b0, 1'b0, NoWant},
    '{32'sd7, 32'sd9, 1'b0, 1'b0, NoWant},
    '{32'sd8, 32'sd6, 1'b0, 1'b0, NoWant},
    '{32'sd13, 32'sd14, 1'b1, 1'b0, NoWant},
    // extremes folded into one run
    '{CoordMax, CoordMax, 1'b0, 1'b0, NoWant},
    '{CoordMin, 32'sd0, 1'b0, 1'b0, NoWant},
    '{-32'sd1, CoordMax, 1'b1, 1'b1, '{CoordMin, CoordMax, 6'd0, 1'b1, 1'b0}},
    // duplicates and negatives
    '{32'sd0, 32'sd0, 1'b0, 1'b0, NoWant},
    '{-32'sd5, -32'sd1, 1'b0, 1'b0, NoWant},
    '{32'sd0, 32'sd0, 1'b1, 1'b0, NoWant}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ium_in_if  in_if ();
  ium_out_if out_if ();

  interval_union_merger_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  span_t       set_spans [$];
  logic        set_overflow;
  merged_t     fresh_merges [$];
  merged_t     pending_merges [$];
  logic        idle_on;
  int unsigned items_sent;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned stuck_cnt = 0;

  // ordering of stored intervals: left end, then right end, both signed
  function automatic logic span_lt(span_t a, span_t b);
    coord_t al, ar, bl, br;
    al = a.left;
    ar = a.right;
    bl = b.left;
    br = b.right;
    return (al < bl) || (al == bl && ar < br);
  endfunction

  // store one interval; on the closing one sort, sweep and fill fresh_merges
  function automatic void fold_interval(coord_t l, coord_t r, logic is_last);
    span_t  sorted [$];
    coord_t cl, cr, run_left, run_right;
    logic   open;
    idx_t   idx;
    int     j;
    fresh_merges.delete();
    if (set_spans.size() < SetCap) set_spans.insert(set_spans.size(), span_t'{l, r});
    else set_overflow = 1'b1;
    if (!is_last) return;
    // stable insertion sort
    foreach (set_spans[i]) begin
      j = sorted.size();
      while (j > 0 && span_lt(set_spans[i], sorted[j-1])) j--;
      sorted.insert(j, set_spans[i]);
    end
    // sweep: merge overlapping or touching, right end only grows
    open = 1'b0;
    idx = '0;
    run_left = '0;
    run_right = '0;
    foreach (sorted[i]) begin
      cl = sorted[i].left;
      cr = sorted[i].right;
      if (!open || run_right < cl) begin
        if (open) begin
          fresh_merges.insert(fresh_merges.size(),
                              merged_t'{run_left, run_right, idx, 1'b0, set_overflow});
          idx++;
        end
        run_left = cl;
        run_right = cr;
        open = 1'b1;
      end else if (run_right < cr) begin
        run_right = cr;
      end
    end
    fresh_merges.insert(fresh_merges.size(),
                        merged_t'{run_left, run_right, idx, 1'b1, set_overflow});
    set_spans.delete();
    set_overflow = 1'b0;
  endfunction

  // one input transaction, with an optional idle burst ahead of it
  task automatic send_interval(input coord_t l, input coord_t r, input logic is_last,
                               input logic typed, input merged_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.left_end  <= l;
    in_if.right_end <= r;
    in_if.set_last  <= is_last;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    fold_interval(l, r, is_last);
    if (typed) pending_merges.insert(pending_merges.size(), want);
    else foreach (fresh_merges[k]) pending_merges.insert(pending_merges.size(), fresh_merges[k]);
  endtask

  // one random set of n intervals, the last one closes it
  task automatic send_random_set(input int unsigned n);
    int unsigned mode;
    coord_t      base, l, r, t;
    mode = $urandom_range(0, 4);
    base = $urandom;
    for (int unsigned k = 0; k < n; k++) begin
      case (mode) inside
        // dense cluster: many overlaps and touches
        [0:2]: begin
          l = base + $urandom_range(0, 60);
          r = l + $urandom_range(0, 10);
          if ($urandom_range(0, 9) == 0) begin
            t = l;
            l = r;
            r = t;
          end
        end
        // full-range fields, mostly ordered
        3: begin
          l = $urandom;
          r = $urandom;
          if (r < l && $urandom_range(0, 3) != 0) begin
            t = l;
            l = r;
            r = t;
          end
        end
        // near the coordinate extremes, may wrap
        default: begin
          l = $urandom_range(0, 1) ? CoordMin + $urandom_range(0, 8)
                                   : CoordMax - $urandom_range(0, 8);
          r = l + $urandom_range(0, 8);
        end
      endcase
      send_interval(l, r, k == n - 1, 1'b0, NoWant);
    end
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // result sink with stall bursts, and the result checker
  always @(posedge clk_i) begin
    merged_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_merges.size() == 0) begin
        $display("%0t: merged_left mismatch, expected none actual %0d", $time,
                 out_if.merged_left);
        mismatch_cnt++;
      end else begin
        want = pending_merges.pop_front();
        check_field("merged_left", want.left, out_if.merged_left);
        check_field("merged_right", want.right, out_if.merged_right);
        check_field("merged_index", want.index, out_if.merged_index);
        check_field("run_last", want.is_last, out_if.run_last);
        check_field("dropped_any", want.dropped, out_if.dropped_any);
      end
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    out_if.ready <= (stall_left == 0);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stuck_cnt <= 0;
    else stuck_cnt <= stuck_cnt + 1;
    if (stuck_cnt == StuckLimit) begin
      $display("interval_union_merger_top_tb failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned set_n, set_len, pick;
    in_if.valid     = 1'b0;
    in_if.left_end  = '0;
    in_if.right_end = '0;
    in_if.set_last  = 1'b0;
    rst_ni          = 1'b0;
    idle_on         = 1'b1;
    set_overflow    = 1'b0;
    items_sent      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < DirN; i++) begin
      send_interval(DirRows[i].left, DirRows[i].right, DirRows[i].set_last,
                    DirRows[i].typed, DirRows[i].want);
    end

    // random sets: first overflows the buffer, second fills it exactly
    set_n = 0;
    while (items_sent < DirN + RandItems) begin
      idle_on <= (items_sent + QuietTail < DirN + RandItems) && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (set_n == 0) set_len = SetCap + 2;
      else if (set_n == 1) set_len = SetCap;
      else if (pick == 0) set_len = SetCap + $urandom_range(0, 5);
      else if (pick == 1) set_len = $urandom_range(16, 40);
      else set_len = $urandom_range(1, 10);
      send_random_set(set_len);
      set_n++;
    end
    in_if.valid <= 1'b0;

    // drain
    while (pending_merges.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("interval_union_merger_top_tb passed");
    end else begin
      $display("interval_union_merger_top_tb failed");
    end
    $finish;
  end

endmodule
